/* hdl/heartbeat_window_monitor_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the heartbeat window monitor
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_WINDOW_MONITOR_CORE_MACROS_SVH
`define HEARTBEAT_WINDOW_MONITOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define HWM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heartbeat monitor check failed");

// Next-cycle implication, sampled on the rising clock edge
`define HWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heartbeat monitor check failed");

`endif

/* hdl/hwm_pkg.sv */
// ----------------------------------------------------------------------------
// Heartbeat window monitor package
// Item types, register indexes, reset values and state layout.
// ----------------------------------------------------------------------------
package hwm_pkg;

   // Event kinds
   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_POLL = 1'b1;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_MIN_GAP  = 2'd0;
   localparam csr_index_type CSR_MAX_GAP  = 2'd1;
   localparam csr_index_type CSR_GOOD_RUN = 2'd2;

   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [15:0] MIN_GAP_RESET  = 16'd5;
   localparam logic [15:0] MAX_GAP_RESET  = 16'd100;
   localparam logic [7:0]  GOOD_RUN_RESET = 8'd3;

   typedef struct packed {
      logic        op;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        alive_out;
      logic [31:0] fast_rejects;
      logic [31:0] slow_rejects;
   } rsp_type;

   typedef struct packed {
      logic [15:0] min_gap_ms;
      logic [15:0] max_gap_ms;
      logic [7:0]  good_run_needed;
   } cfg_type;

   typedef struct packed {
      logic        seen_edge;
      logic [31:0] last_edge_time;
      logic [7:0]  run_count;
      logic        alive_flag;
      logic [31:0] fast_count;
      logic [31:0] slow_count;
   } state_type;

endpackage

/* hdl/hwm_judge.sv */
// ----------------------------------------------------------------------------
// Heartbeat judge
// Next-state and result logic for one edge or poll item.
// ----------------------------------------------------------------------------
module hwm_judge (
   input  hwm_pkg::cfg_type   cfg,
   input  hwm_pkg::state_type state_cur,
   input  hwm_pkg::req_type   item,
   output hwm_pkg::state_type state_nxt,
   output hwm_pkg::rsp_type   rsp
);
   import hwm_pkg::*;

   logic [31:0] gap;
   logic        too_fast;
   logic        too_slow;
   logic        silent;
   logic [7:0]  run_up;

   // Measure the gap since the last edge, wrapping
   always_comb begin
      gap      = item.now_ms - state_cur.last_edge_time;
      too_fast = gap < {16'd0, cfg.min_gap_ms};
      too_slow = gap > {16'd0, cfg.max_gap_ms};
      silent   = !state_cur.seen_edge || (gap >= {16'd0, cfg.max_gap_ms});
      run_up   = (state_cur.run_count < cfg.good_run_needed) ?
                 state_cur.run_count + 8'd1 : state_cur.run_count;
   end

   // Update state for the item kind
   always_comb begin
      state_nxt = state_cur;
      if (item.op == OP_EDGE) begin
         state_nxt.seen_edge      = 1'b1;
         state_nxt.last_edge_time = item.now_ms;
         if (state_cur.seen_edge) begin
            if (too_fast) begin
               state_nxt.fast_count = state_cur.fast_count + 32'd1;
               state_nxt.run_count  = 8'd0;
               state_nxt.alive_flag = 1'b0;
            end else if (too_slow) begin
               state_nxt.slow_count = state_cur.slow_count + 32'd1;
               state_nxt.run_count  = 8'd0;
               state_nxt.alive_flag = 1'b0;
            end else begin
               state_nxt.run_count = run_up;
               if (run_up >= cfg.good_run_needed) begin
                  state_nxt.alive_flag = 1'b1;
               end
            end
         end
      end else if (silent) begin
         // Count a silence only when the line had any credit
         if (state_cur.alive_flag || (state_cur.run_count != 8'd0)) begin
            state_nxt.slow_count = state_cur.slow_count + 32'd1;
         end
         state_nxt.run_count  = 8'd0;
         state_nxt.alive_flag = 1'b0;
      end
   end

   // Report the status after this item
   always_comb begin
      rsp.alive_out    = state_nxt.alive_flag;
      rsp.fast_rejects = state_nxt.fast_count;
      rsp.slow_rejects = state_nxt.slow_count;
   end

endmodule

/* hdl/heartbeat_window_monitor_core.sv */
// An item passes from the input register through the judge to the result register.
// Throughput: one item per cycle while rsp_ready does not stall the output;
// the judge logic between the two registers is combinational.
// Reset: synchronous, clears all monitor state and both stage valids and
// loads the register reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Heartbeat window monitor core
// Input register, combinational judge and result register with handshakes.
// ----------------------------------------------------------------------------
module heartbeat_window_monitor_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  hwm_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output hwm_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  hwm_pkg::csr_index_type              csr_index,
   input  logic [hwm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import hwm_pkg::*;

   logic      stage_valid_ff, stage_valid_in;
   req_type   stage_item_ff, stage_item_in;
   state_type state_ff, state_in;
   cfg_type   cfg_ff, cfg_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_item_ff, rsp_item_in;

   logic      out_free;
   logic      advance;
   state_type judge_state;
   rsp_type   judge_rsp;

   hwm_judge u_judge (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .item      (stage_item_ff),
      .state_nxt (judge_state),
      .rsp       (judge_rsp)
   );

   // Handshake and stage control
   always_comb begin
      out_free       = !rsp_valid_ff || rsp_ready;
      advance        = stage_valid_ff && out_free;
      req_ready      = !stage_valid_ff || advance;
      stage_valid_in = req_ready ? req_valid : stage_valid_ff;
      stage_item_in  = (req_valid && req_ready) ? req_data : stage_item_ff;
      state_in       = advance ? judge_state : state_ff;
      rsp_valid_in   = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_item_in    = advance ? judge_rsp : rsp_item_ff;
   end

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_GAP:  cfg_in.min_gap_ms      = csr_wdata;
            CSR_MAX_GAP:  cfg_in.max_gap_ms      = csr_wdata;
            CSR_GOOD_RUN: cfg_in.good_run_needed = csr_wdata[7:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   // Control and monitor state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= '0;
         cfg_ff.min_gap_ms      <= MIN_GAP_RESET;
         cfg_ff.max_gap_ms      <= MAX_GAP_RESET;
         cfg_ff.good_run_needed <= GOOD_RUN_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         state_ff       <= state_in;
         cfg_ff         <= cfg_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      stage_item_ff <= stage_item_in;
      rsp_item_ff   <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

endmodule

/* hdl/hwm_checker.sv */
// ----------------------------------------------------------------------------
// Heartbeat window monitor checker
// Port-level checks on the monitor core, bound to the monitor core module.
// ----------------------------------------------------------------------------
`include "heartbeat_window_monitor_core_macros.svh"

module hwm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input hwm_pkg::rsp_type rsp_data
);
   import hwm_pkg::*;

   // Hold a stalled result item
   `HWM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Reset empties the result side
   `HWM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready)

   // An item taken while no result is held shows a result after the input and result registers
   `HWM_ASSERT_NEXT(a_result_follows, clock, reset, req_valid && req_ready && !rsp_valid, ##1 rsp_valid)

   // With the output free, the input side always takes items
   `HWM_ASSERT_NOW(a_ready_when_free, clock, reset, !rsp_valid, req_ready)

endmodule

bind heartbeat_window_monitor_core hwm_checker u_hwm_checker (.*);
